// ===== hw/rtl/vsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsp_pkg
// Shared types, register codes, reset values and the colour palette for the
// vga scanout block.
// ----------------------------------------------------------------------------
package vsp_pkg;

  // geometry defaults for the frame buffer
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;

  // configuration port
  localparam int REG_W     = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_H_TOTAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HSYNC_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HSYNC_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_V_TOTAL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_V_VISIBLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_START = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_LEN   = 3'd6;

  // register reset values
  localparam logic [REG_W-1:0] H_TOTAL_RST     = 10'd400;
  localparam logic [REG_W-1:0] HSYNC_START_RST = 10'd328;
  localparam logic [REG_W-1:0] HSYNC_LEN_RST   = 10'd48;
  localparam logic [REG_W-1:0] V_TOTAL_RST     = 10'd525;
  localparam logic [REG_W-1:0] V_VISIBLE_RST   = 10'd480;
  localparam logic [REG_W-1:0] VSYNC_START_RST = 10'd490;
  localparam logic [REG_W-1:0] VSYNC_LEN_RST   = 10'd2;

  // item operations
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [15:0]       fb_addr;
    logic [7:0]        fb_data;
  } vsp_in_t;

  typedef struct packed {
    logic [5:0]        color;
    logic              hsync_n;
    logic              vsync_n;
    logic              active;
  } vsp_out_t;

  typedef struct packed {
    logic [REG_W-1:0]  h_total;
    logic [REG_W-1:0]  hsync_start;
    logic [REG_W-1:0]  hsync_len;
    logic [REG_W-1:0]  v_total;
    logic [REG_W-1:0]  v_visible;
    logic [REG_W-1:0]  vsync_start;
    logic [REG_W-1:0]  vsync_len;
  } vsp_cfg_t;

  // per-pixel raster status handed from timing to the output stage
  typedef struct packed {
    logic              active;
    logic              hsync_n;
    logic              vsync_n;
    logic              odd;
  } vsp_pix_t;

  // fixed 16-entry palette, 2 bits per channel
  function automatic logic [5:0] palette6(input logic [3:0] nib);
    logic [5:0] c;
    case (nib)
      4'h0:    c = 6'h00;
      4'h1:    c = 6'h02;
      4'h2:    c = 6'h20;
      4'h3:    c = 6'h22;
      4'h4:    c = 6'h08;
      4'h5:    c = 6'h0A;
      4'h6:    c = 6'h28;
      4'h7:    c = 6'h2A;
      4'h8:    c = 6'h00;
      4'h9:    c = 6'h03;
      4'hA:    c = 6'h30;
      4'hB:    c = 6'h33;
      4'hC:    c = 6'h0C;
      4'hD:    c = 6'h0F;
      4'hE:    c = 6'h3C;
      4'hF:    c = 6'h3F;
      default: c = 6'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vsp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module vsp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/vsp_timing.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsp_timing
// Raster counters with sync windows. Tracks the buffer row and its byte base
// alongside the line counter so the read address needs no multiply or modulo.
// ----------------------------------------------------------------------------
module vsp_timing #(
  parameter int SCREEN_WIDTH  = vsp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = vsp_pkg::SCREEN_HEIGHT_DEF,
  parameter int ADDR_W        = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vsp_pkg::vsp_cfg_t cfg,
  input  wire logic              advance,
  output vsp_pkg::vsp_pix_t      pix,
  output logic [ADDR_W-1:0]      rd_addr
);
  import vsp_pkg::*;

  localparam int ROW_BYTES = (SCREEN_WIDTH + 1) / 2;
  localparam int ROW_W     = $clog2(SCREEN_HEIGHT + 1);

  logic [REG_W-1:0]  h_r, h_nxt, v_r, v_nxt;
  logic [REG_W-1:0]  h_inc, v_inc, h_off, v_off;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              h_wrap, v_wrap, row_last;

  // sync windows and visible area for the current position
  always_comb begin
    h_off       = h_r - cfg.hsync_start;
    v_off       = v_r - cfg.vsync_start;
    pix.active  = ({1'b0, h_r} < (REG_W+1)'(SCREEN_WIDTH)) && (v_r < cfg.v_visible);
    pix.hsync_n = !((h_r >= cfg.hsync_start) && (h_off < cfg.hsync_len));
    pix.vsync_n = !((v_r >= cfg.vsync_start) && (v_off < cfg.vsync_len));
    pix.odd     = h_r[0];
  end

  assign rd_addr = base_r + ADDR_W'(h_r[REG_W-1:1]);

  // counter advance; a new even line moves on to the next buffer row
  always_comb begin
    h_inc    = h_r + 10'd1;
    v_inc    = v_r + 10'd1;
    h_wrap   = (h_inc >= cfg.h_total) || (h_inc == '0);
    v_wrap   = (v_inc >= cfg.v_total) || (v_inc == '0);
    row_last = (row_r == ROW_W'(SCREEN_HEIGHT - 1));
    h_nxt    = h_r;
    v_nxt    = v_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    if (advance) begin
      if (!h_wrap) begin
        h_nxt = h_inc;
      end else begin
        h_nxt = '0;
        if (v_wrap) begin
          v_nxt    = '0;
          row_nxt  = '0;
          base_nxt = '0;
        end else begin
          v_nxt = v_inc;
          if (!v_inc[0]) begin
            if (row_last) begin
              row_nxt  = '0;
              base_nxt = '0;
            end else begin
              row_nxt  = row_r + ROW_W'(1);
              base_nxt = base_r + ADDR_W'(ROW_BYTES);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r    <= '0;
      v_r    <= '0;
      row_r  <= '0;
      base_r <= '0;
    end else begin
      h_r    <= h_nxt;
      v_r    <= v_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vsp_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsp_out_stage
// Read-data stage and output register: picks the nibble from the buffer byte,
// maps it through the palette and holds the result until it is taken.
// ----------------------------------------------------------------------------
module vsp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              issue,
  input  wire vsp_pkg::vsp_pix_t pix,
  input  wire logic [7:0]        rd_data,
  output logic                   s1_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vsp_pkg::vsp_out_t      out_data
);
  import vsp_pkg::*;

  logic     s1_valid_r, out_valid_r;
  vsp_pix_t s1_pix_r;
  vsp_out_t out_data_r;
  vsp_out_t res;
  logic     out_free;
  logic [3:0] nib;

  assign out_free = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || out_free;

  // colour lookup from the byte returned by the buffer
  always_comb begin
    nib         = s1_pix_r.odd ? rd_data[7:4] : rd_data[3:0];
    res.color   = s1_pix_r.active ? palette6(nib) : 6'd0;
    res.hsync_n = s1_pix_r.hsync_n;
    res.vsync_n = s1_pix_r.vsync_n;
    res.active  = s1_pix_r.active;
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pix_r <= pix;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/vga_scanout_palette_timing_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vga_scanout_palette_timing_top
// VGA scanout with a 4-bit-per-pixel frame buffer, fixed palette and
// programmable raster timing.
//
//   port group | direction | transfer when          | payload
//   in_        | in        | in_valid && in_ready   | vsp_in_t  (op, fb_addr, fb_data)
//   out_       | out       | out_valid && out_ready | vsp_out_t (color, syncs, active)
//   cfg_       | in        | cfg_we                 | cfg_index, cfg_data
//
// One item is taken per cycle while in_ready is high. A tick transfer's pixel
// passes the frame buffer read register, then the palette output register.
// After reset the buffer is swept to zero, one byte a cycle (38400 bytes at
// the default geometry); in_ready stays low meanwhile, cfg writes still land.
// A stalled output holds one pixel in the read stage; in_ready drops once
// both the read stage and the output register are full.
// ----------------------------------------------------------------------------
module vga_scanout_palette_timing_top #(
  parameter int SCREEN_WIDTH  = vsp_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = vsp_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire vsp_pkg::vsp_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output vsp_pkg::vsp_out_t                   out_data,
  input  wire logic                           cfg_we,
  input  wire logic [vsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vsp_pkg::REG_W-1:0]      cfg_data
);
  import vsp_pkg::*;

  localparam int ROW_BYTES = (SCREEN_WIDTH + 1) / 2;
  localparam int FB_BYTES  = ROW_BYTES * SCREEN_HEIGHT;
  localparam int ADDR_W    = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;

  vsp_cfg_t          cfg_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              in_xfer, tick_xfer, wr_xfer, s1_ready;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, rd_addr;
  logic [7:0]        ram_wdata, rd_data;
  vsp_pix_t          pix;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.h_total     <= H_TOTAL_RST;
      cfg_r.hsync_start <= HSYNC_START_RST;
      cfg_r.hsync_len   <= HSYNC_LEN_RST;
      cfg_r.v_total     <= V_TOTAL_RST;
      cfg_r.v_visible   <= V_VISIBLE_RST;
      cfg_r.vsync_start <= VSYNC_START_RST;
      cfg_r.vsync_len   <= VSYNC_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_H_TOTAL:     cfg_r.h_total     <= cfg_data;
        CFG_HSYNC_START: cfg_r.hsync_start <= cfg_data;
        CFG_HSYNC_LEN:   cfg_r.hsync_len   <= cfg_data;
        CFG_V_TOTAL:     cfg_r.v_total     <= cfg_data;
        CFG_V_VISIBLE:   cfg_r.v_visible   <= cfg_data;
        CFG_VSYNC_START: cfg_r.vsync_start <= cfg_data;
        CFG_VSYNC_LEN:   cfg_r.vsync_len   <= cfg_data;
        default:         ;
      endcase
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(FB_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // input transfer decode; writes beyond the buffer are dropped
  assign in_ready  = !clr_busy_r && s1_ready;
  assign in_xfer   = in_valid && in_ready;
  assign tick_xfer = in_xfer && (in_data.op == OP_TICK);
  assign wr_xfer   = in_xfer && (in_data.op == OP_WRITE)
                     && (32'(in_data.fb_addr) < 32'(FB_BYTES));

  // buffer write port shared by the sweep and write items
  assign ram_we    = clr_busy_r || wr_xfer;
  assign ram_waddr = clr_busy_r ? clr_addr_r : ADDR_W'(in_data.fb_addr);
  assign ram_wdata = clr_busy_r ? 8'd0 : in_data.fb_data;

  // a write lands at its transfer edge, so a tick in the next cycle reads it
  vsp_ram #(
    .WIDTH  (8),
    .DEPTH  (FB_BYTES),
    .ADDR_W (ADDR_W)
  ) u_fb (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (tick_xfer),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  vsp_timing #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ADDR_W        (ADDR_W)
  ) u_timing (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .advance (tick_xfer),
    .pix     (pix),
    .rd_addr (rd_addr)
  );

  vsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (tick_xfer),
    .pix       (pix),
    .rd_data   (rd_data),
    .s1_ready  (s1_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
